>>> src/lmbs_pkg.sv
package lmbs_pkg;

  // Frame store geometry
  localparam int STORE_AW    = 13;
  localparam int STORE_DEPTH = 1 << STORE_AW;

  // Field widths
  localparam int PIXEL_W  = 16;
  localparam int BRIGHT_W = 8;
  localparam int ONTIME_W = 16;
  localparam int PLANE_W  = 3;
  localparam int ROWOUT_W = 5;
  localparam int COLOR_W  = 6;

  // Stream payload widths
  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  // Defaults for the top-level parameters
  localparam int DEF_PANEL_WIDTH_PIXELS = 128;
  localparam int DEF_ROW_SELECT_BITS    = 5;
  localparam int DEF_PLANE_COUNT        = 8;
  localparam logic [BRIGHT_W-1:0] BRIGHTNESS_RESET = 8'd100;

  // Input kind codes
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  // Scan phases
  typedef enum logic [3:0] {
    PH_SHIFT     = 4'b0001,
    PH_UNLATCHED = 4'b0010,
    PH_LATCH     = 4'b0100,
    PH_DISPLAY   = 4'b1000
  } scan_phase_t;

  // Gamma-correct an RGB565 pixel by squaring and pick one bit plane: {b, g, r}
  function automatic logic [2:0] plane_slice(input logic [PIXEL_W-1:0] pix,
                                             input logic [PLANE_W-1:0] plane);
    logic [9:0]  r_sq;
    logic [11:0] g_sq;
    logic [9:0]  b_sq;
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    r_sq = 10'(pix[15:11]) * 10'(pix[15:11]);
    g_sq = 12'(pix[10:5]) * 12'(pix[10:5]);
    b_sq = 10'(pix[4:0]) * 10'(pix[4:0]);
    r8 = r_sq[9:2];
    g8 = g_sq[11:4];
    b8 = b_sq[9:2];
    return {b8[plane], g8[plane], r8[plane]};
  endfunction

endpackage

>>> src/led_matrix_bitplane_scanner_top.sv
// Channel  | Dir | Signals                       | Payload (lowest bit first)
// s        | in  | s_tvalid s_tready s_tdata     | s_tdata: pixel_address[12:0],
//          |     | s_tuser                       |   pixel_value[28:13]; s_tuser: kind
// m        | out | m_tvalid m_tready m_tdata     | m_tdata: color_bits[5:0], shift_clock[6],
//          |     |                               |   latch_strobe[7], output_enable_n[8],
//          |     |                               |   row_address[13:9]
// cfg      | in  | cfg_we cfg_wdata              | brightness
//
// One transaction is taken per cycle, pixel writes and ticks alike, while s_tready is high.
// A tick result passes through the frame store read (stage 1) and then the output register.
// After reset a clearing pass zeroes the 8192-entry frame store, one entry per cycle, with
// s_tready low until the pass ends. A stalled m_tready holds the pipeline; input is taken
// while one result waits in the output register.
module led_matrix_bitplane_scanner_top
  import lmbs_pkg::*;
#(
  parameter int PANEL_WIDTH_PIXELS = DEF_PANEL_WIDTH_PIXELS,
  parameter int ROW_SELECT_BITS    = DEF_ROW_SELECT_BITS,
  parameter int PLANE_COUNT        = DEF_PLANE_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // pixel_address[12:0], pixel_value[28:13]
  input  logic                 s_tuser,   // kind
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // color_bits[5:0], shift_clock, latch_strobe,
                                          // output_enable_n, row_address[13:9]
  input  logic                 cfg_we,
  input  logic [BRIGHT_W-1:0]  cfg_wdata
);

  localparam int COL_W = $clog2(PANEL_WIDTH_PIXELS);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(PANEL_WIDTH_PIXELS - 1);
  localparam logic [PLANE_W-1:0] PLANE_LAST = PLANE_W'(PLANE_COUNT - 1);
  localparam logic [STORE_AW-1:0] BOT_OFS =
    STORE_AW'(((1 << ROW_SELECT_BITS) * PANEL_WIDTH_PIXELS) % STORE_DEPTH);
  localparam logic [STORE_AW-1:0] WIDTH_A = STORE_AW'(PANEL_WIDTH_PIXELS);

  // Frame store
  logic [PIXEL_W-1:0] frame_mem [STORE_DEPTH];
  logic [PIXEL_W-1:0] rd_top;
  logic [PIXEL_W-1:0] rd_bot;

  // Clearing pass
  logic                clearing;
  logic [STORE_AW-1:0] clr_addr;

  // Scan state
  logic [BRIGHT_W-1:0]        brightness;
  logic [ROW_SELECT_BITS-1:0] scan_row, scan_row_next;
  logic [PLANE_W-1:0]         plane_index, plane_index_next;
  logic [COL_W-1:0]           column_count, column_count_next;
  logic                       clock_half, clock_half_next;
  scan_phase_t                scan_phase, scan_phase_next;
  logic [ONTIME_W-1:0]        on_time_left, on_time_left_next;

  // Per-tick result fields known at accept time
  logic p_shift, p_clk, p_lat, p_oen;

  // Stage 1 (waiting on frame store read data)
  logic                s1_valid;
  logic                s1_shift, s1_clk, s1_lat, s1_oen;
  logic [ROWOUT_W-1:0] s1_row;
  logic [PLANE_W-1:0]  s1_plane;

  logic                out_free, s1_move, s_acc, tick_acc, pix_acc, mem_we;
  logic [STORE_AW-1:0] top_addr, bot_addr, wr_addr;
  logic [PIXEL_W-1:0]  wr_data;
  logic [COLOR_W-1:0]  color;

  // Handshake
  assign out_free = !m_tvalid || m_tready;
  assign s1_move  = s1_valid && out_free;
  assign s_tready = !clearing && (!s1_valid || out_free);
  assign s_acc    = s_tvalid && s_tready;
  assign tick_acc = s_acc && (s_tuser == KIND_TICK);
  assign pix_acc  = s_acc && (s_tuser == KIND_PIXEL);

  // Frame addresses of the current column, top and bottom halves
  assign top_addr = STORE_AW'(STORE_AW'(scan_row) * WIDTH_A) + STORE_AW'(column_count);
  assign bot_addr = top_addr + BOT_OFS;

  // Write port: clearing pass or pixel write
  assign mem_we  = clearing || pix_acc;
  assign wr_addr = clearing ? clr_addr : s_tdata[STORE_AW-1:0];
  assign wr_data = clearing ? '0 : s_tdata[STORE_AW +: PIXEL_W];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[wr_addr] <= wr_data;
    end
  end

  // Read both pixels of the column; hold while stalled
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      rd_top <= frame_mem[top_addr];
      rd_bot <= frame_mem[bot_addr];
    end
  end

  // Sweep the store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == '1) begin
        clearing <= 1'b0;
      end
    end
  end

  // Brightness register
  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= BRIGHTNESS_RESET;
    end else if (cfg_we) begin
      brightness <= cfg_wdata;
    end
  end

  // Advance the scan by one tick
  always_comb begin
    scan_row_next     = scan_row;
    plane_index_next  = plane_index;
    column_count_next = column_count;
    clock_half_next   = clock_half;
    scan_phase_next   = scan_phase;
    on_time_left_next = on_time_left;
    p_shift = 1'b0;
    p_clk   = 1'b0;
    p_lat   = 1'b0;
    p_oen   = 1'b1;
    case (scan_phase)
      PH_SHIFT: begin
        p_shift = 1'b1;
        p_clk   = clock_half;
        if (!clock_half) begin
          clock_half_next = 1'b1;
        end else begin
          clock_half_next = 1'b0;
          if (column_count == COL_LAST) begin
            column_count_next = '0;
            scan_phase_next   = PH_UNLATCHED;
          end else begin
            column_count_next = column_count + 1'b1;
          end
        end
      end
      PH_UNLATCHED: begin
        scan_phase_next = PH_LATCH;
      end
      PH_LATCH: begin
        p_lat = 1'b1;
        on_time_left_next = (ONTIME_W'(brightness) << plane_index) + 1'b1;
        scan_phase_next   = PH_DISPLAY;
      end
      PH_DISPLAY: begin
        p_oen = 1'b0;
        if (on_time_left <= ONTIME_W'(1)) begin
          on_time_left_next = '0;
          column_count_next = '0;
          clock_half_next   = 1'b0;
          scan_phase_next   = PH_SHIFT;
          if (plane_index == PLANE_LAST) begin
            plane_index_next = '0;
            scan_row_next    = scan_row + 1'b1;
          end else begin
            plane_index_next = plane_index + 1'b1;
          end
        end else begin
          on_time_left_next = on_time_left - 1'b1;
        end
      end
      default: begin
        scan_phase_next = PH_SHIFT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row     <= '0;
      plane_index  <= '0;
      column_count <= '0;
      clock_half   <= 1'b0;
      scan_phase   <= PH_SHIFT;
      on_time_left <= '0;
    end else if (tick_acc) begin
      scan_row     <= scan_row_next;
      plane_index  <= plane_index_next;
      column_count <= column_count_next;
      clock_half   <= clock_half_next;
      scan_phase   <= scan_phase_next;
      on_time_left <= on_time_left_next;
    end
  end

  // Stage 1: carry the tick fields alongside the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      s1_shift <= p_shift;
      s1_clk   <= p_clk;
      s1_lat   <= p_lat;
      s1_oen   <= p_oen;
      s1_row   <= ROWOUT_W'(scan_row_next);
      s1_plane <= plane_index;
    end
  end

  // Gamma and plane slice of both pixels; zero outside the shift phase
  assign color = s1_shift ? {plane_slice(rd_bot, s1_plane), plane_slice(rd_top, s1_plane)}
                          : '0;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      m_tdata <= M_TDATA_W'({s1_row, s1_oen, s1_lat, s1_clk, color});
    end
  end

endmodule
